// File: rtl/gfea_pkg.sv
// Package for the gated feed-forward expert accumulator.
// Holds widths, action and state codes, item types, the SiLU table and shared helpers.
// No dependencies.
package gfea_pkg;

	localparam int HID_MAX_DEF    = 32;
	localparam int INTER_SIZE_DEF = 64;
	localparam int HID_CFG_W = 6;
	localparam int INT_CFG_W = 7;

	localparam logic [1:0] ACT_LOAD_W  = 2'd0;
	localparam logic [1:0] ACT_LOAD_X  = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;
	localparam logic [1:0] ACT_CLEAR   = 2'd3;

	localparam logic [1:0] SEL_GATE = 2'd0;
	localparam logic [1:0] SEL_UP   = 2'd1;
	localparam logic [1:0] SEL_DOWN = 2'd2;

	localparam logic CFG_HIDDEN = 1'b0;
	localparam logic CFG_INTER  = 1'b1;

	typedef struct packed {
		logic [1:0]         action;
		logic [1:0]         matrix_sel;
		logic [5:0]         row_index;
		logic [5:0]         col_index;
		logic signed [15:0] value;
		logic [15:0]        route_gain;
	} in_item_t;

	typedef struct packed {
		logic [4:0]         element_index;
		logic signed [31:0] element_value;
		logic               last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_P1_MAC,
		ST_P1_DRAIN,
		ST_P1_ROUND,
		ST_P1_SILU,
		ST_P1_GATE,
		ST_P2_MAC,
		ST_P2_DRAIN,
		ST_P2_SCALE,
		ST_P2_ACC,
		ST_P2_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       clr_acc;
		logic       p1_mac;
		logic       p1_round;
		logic       p1_silu;
		logic       p1_gate;
		logic       p2_mac;
		logic       p2_scale;
		logic       p2_acc;
		logic       emit;
		logic       sum_clr;
		logic [7:0] j;
		logic [7:0] k;
		logic       last;
	} dp_cmd_t;

	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
		logic signed [63:0] t;
		t = v + (64'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	// shift and subtract quotient, only ever evaluated while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q, rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// SiLU(-8 + i/16) in Q.12
	function automatic logic signed [17:0] silu_tab(input logic [7:0] i);
		logic [63:0] e, den, num, ax;
		logic signed [17:0] r;
		int n, mag;
		e = 64'd1 << 32;
		n = int'(i) - 128;
		mag = (n < 0) ? -n : n;
		ax = 64'(mag) * 64'd256;
		for (int k = 0; k < 128; k++) begin
			if (k < mag)
				e = (k == 0) ? 64'd4034748381 : ((e * 64'd4034748381 + (64'd1 << 31)) >> 32);
		end
		den = (64'd1 << 32) + e;
		if (n >= 0) begin
			num = ax << 32;
			r = 18'(udiv64(num + (den >> 1), den));
		end else begin
			num = ax * e;
			r = -18'(udiv64(num + (den >> 1), den));
		end
		return r;
	endfunction

	typedef logic signed [17:0] tab_arr_t [256];

	function automatic tab_arr_t build_tab();
		tab_arr_t t;
		for (int i = 0; i < 256; i++)
			t[i] = silu_tab(8'(i));
		return t;
	endfunction

	localparam tab_arr_t SILU_TAB = build_tab();

endpackage

// File: rtl/gfea_ctrl.sv
// Controller for the gated feed-forward expert accumulator.
// Sequences both projections, the SiLU gating and the down pass; uses gfea_pkg.
module gfea_ctrl #(
	parameter int HID_MAX     = gfea_pkg::HID_MAX_DEF,
	parameter int INTER_SIZE  = gfea_pkg::INTER_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go_compute,
	input  logic                         go_clear,
	input  logic [7:0]                   h_cnt,
	input  logic [8:0]                   n_cnt,
	output logic                         busy,
	output gfea_pkg::dp_cmd_t            cmd
);

	gfea_pkg::state_t state_q, state_d;
	logic [7:0] j_q, j_d, k_q, k_d;
	logic [1:0] drn_q, drn_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfea_pkg::ST_IDLE;
			j_q     <= '0;
			k_q     <= '0;
			drn_q   <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			k_q     <= k_d;
			drn_q   <= drn_d;
		end
	end

	always_comb begin
		state_d = state_q;
		j_d = j_q;
		k_d = k_q;
		drn_d = drn_q;
		cmd = '0;
		cmd.j = j_q;
		cmd.k = k_q;
		cmd.last = ({1'b0, j_q} == {1'b0, h_cnt} - 9'd1);
		busy = (state_q != gfea_pkg::ST_IDLE);
		case (state_q)
			gfea_pkg::ST_IDLE: begin
				j_d = '0;
				k_d = '0;
				if (go_clear)
					state_d = gfea_pkg::ST_CLEAR;
				else if (go_compute) begin
					cmd.sum_clr = 1'b1;
					state_d = gfea_pkg::ST_P1_MAC;
				end
			end
			gfea_pkg::ST_CLEAR: begin
				cmd.clr_acc = 1'b1;
				state_d = gfea_pkg::ST_IDLE;
			end
			gfea_pkg::ST_P1_MAC: begin
				cmd.p1_mac = 1'b1;
				if ({1'b0, k_q} == {1'b0, h_cnt} - 9'd1) begin
					k_d = '0;
					drn_d = 2'd2;
					state_d = gfea_pkg::ST_P1_DRAIN;
				end else
					k_d = k_q + 8'd1;
			end
			gfea_pkg::ST_P1_DRAIN: begin
				drn_d = drn_q - 2'd1;
				if (drn_q == 2'd0)
					state_d = gfea_pkg::ST_P1_ROUND;
			end
			gfea_pkg::ST_P1_ROUND: begin
				cmd.p1_round = 1'b1;
				state_d = gfea_pkg::ST_P1_SILU;
			end
			gfea_pkg::ST_P1_SILU: begin
				cmd.p1_silu = 1'b1;
				state_d = gfea_pkg::ST_P1_GATE;
			end
			gfea_pkg::ST_P1_GATE: begin
				cmd.p1_gate = 1'b1;
				cmd.sum_clr = 1'b1;
				if ({1'b0, j_q} == n_cnt - 9'd1) begin
					j_d = '0;
					state_d = gfea_pkg::ST_P2_MAC;
				end else begin
					j_d = j_q + 8'd1;
					state_d = gfea_pkg::ST_P1_MAC;
				end
			end
			gfea_pkg::ST_P2_MAC: begin
				cmd.p2_mac = 1'b1;
				if ({1'b0, k_q} == n_cnt - 9'd1) begin
					k_d = '0;
					drn_d = 2'd2;
					state_d = gfea_pkg::ST_P2_DRAIN;
				end else
					k_d = k_q + 8'd1;
			end
			gfea_pkg::ST_P2_DRAIN: begin
				drn_d = drn_q - 2'd1;
				if (drn_q == 2'd0)
					state_d = gfea_pkg::ST_P2_SCALE;
			end
			gfea_pkg::ST_P2_SCALE: begin
				cmd.p2_scale = 1'b1;
				state_d = gfea_pkg::ST_P2_ACC;
			end
			gfea_pkg::ST_P2_ACC: begin
				cmd.p2_acc = 1'b1;
				state_d = gfea_pkg::ST_P2_EMIT;
			end
			gfea_pkg::ST_P2_EMIT: begin
				cmd.emit = 1'b1;
				cmd.sum_clr = 1'b1;
				if (cmd.last) begin
					j_d = '0;
					state_d = gfea_pkg::ST_IDLE;
				end else begin
					j_d = j_q + 8'd1;
					state_d = gfea_pkg::ST_P2_MAC;
				end
			end
			default: state_d = gfea_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_clr_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gfea_pkg::ST_CLEAR |=> state_q == gfea_pkg::ST_IDLE)
		else $error("clear did not return to idle");
	a_emit_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gfea_pkg::ST_P2_EMIT |-> $past(state_q) == gfea_pkg::ST_P2_ACC)
		else $error("emit without accumulate");
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gfea_pkg::ST_P2_MAC |-> {1'b0, j_q} < {1'b0, h_cnt})
		else $error("output index out of range");
`endif

endmodule

// File: rtl/gfea_datapath.sv
// Datapath for the gated feed-forward expert accumulator.
// Weight and vector memories, one shared pair of MACs, SiLU interpolation; uses gfea_pkg.
module gfea_datapath #(
	parameter int HID_MAX     = gfea_pkg::HID_MAX_DEF,
	parameter int INTER_SIZE  = gfea_pkg::INTER_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_en,
	input  gfea_pkg::in_item_t  item,
	input  logic                latch_rw,
	input  gfea_pkg::dp_cmd_t   cmd,
	output gfea_pkg::out_item_t result,
	output logic                result_valid
);

	localparam int HW = (HID_MAX > 1) ? $clog2(HID_MAX) : 1;
	localparam int IW = (INTER_SIZE > 1) ? $clog2(INTER_SIZE) : 1;
	localparam int DEPTH = HID_MAX * INTER_SIZE;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [15:0] gate_mem [DEPTH];
	logic signed [15:0] up_mem   [DEPTH];
	logic signed [15:0] down_mem [DEPTH];
	logic signed [15:0] tok_mem  [HID_MAX];
	logic signed [15:0] gv_mem   [INTER_SIZE];
	logic signed [31:0] acc_q    [HID_MAX];

	logic [15:0] rw_q;

	// loads
	logic in_gu, in_dn;
	logic [AW-1:0] ld_gu_addr, ld_dn_addr;
	assign in_gu = (32'(item.row_index) < HID_MAX) && (32'(item.col_index) < INTER_SIZE);
	assign in_dn = (32'(item.row_index) < INTER_SIZE) && (32'(item.col_index) < HID_MAX);
	assign ld_gu_addr = AW'(32'(item.row_index) * INTER_SIZE + 32'(item.col_index));
	assign ld_dn_addr = AW'(32'(item.row_index) * HID_MAX + 32'(item.col_index));

	always_ff @(posedge clk) begin
		if (load_en && item.action == gfea_pkg::ACT_LOAD_W) begin
			if (item.matrix_sel == gfea_pkg::SEL_GATE && in_gu)
				gate_mem[ld_gu_addr] <= item.value;
			if (item.matrix_sel == gfea_pkg::SEL_UP && in_gu)
				up_mem[ld_gu_addr] <= item.value;
			if (item.matrix_sel == gfea_pkg::SEL_DOWN && in_dn)
				down_mem[ld_dn_addr] <= item.value;
		end
		if (load_en && item.action == gfea_pkg::ACT_LOAD_X && 32'(item.col_index) < HID_MAX)
			tok_mem[item.col_index[HW-1:0]] <= item.value;
		if (latch_rw)
			rw_q <= item.route_gain;
	end

	// stage 1: memory reads
	logic signed [15:0] g_s1, u_s1, x_s1, gv_s1, d_s1;
	logic v1_s1, v2_s1, v1_s2, v2_s2;
	logic [AW-1:0] rd_gu, rd_dn;
	assign rd_gu = AW'(32'(cmd.k) * INTER_SIZE + 32'(cmd.j));
	assign rd_dn = AW'(32'(cmd.k) * HID_MAX + 32'(cmd.j));

	always_ff @(posedge clk) begin
		g_s1  <= gate_mem[rd_gu];
		u_s1  <= up_mem[rd_gu];
		x_s1  <= tok_mem[cmd.k[HW-1:0]];
		d_s1  <= down_mem[rd_dn];
		gv_s1 <= gv_mem[cmd.k[IW-1:0]];
	end

	// stage 2: multiply, then accumulate
	logic signed [31:0] pg_s2, pu_s2;
	logic signed [47:0] gs_q, us_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s1 <= 1'b0;
			v1_s2 <= 1'b0;
			v2_s2 <= 1'b0;
		end else begin
			v1_s1 <= cmd.p1_mac;
			v2_s1 <= cmd.p2_mac;
			v1_s2 <= v1_s1;
			v2_s2 <= v2_s1;
		end
	end

	always_ff @(posedge clk) begin
		pg_s2 <= v1_s1 ? x_s1 * g_s1 : gv_s1 * d_s1;
		pu_s2 <= x_s1 * u_s1;
		if (cmd.sum_clr) begin
			gs_q <= '0;
			us_q <= '0;
		end else if (v1_s2) begin
			gs_q <= gs_q + 48'(pg_s2);
			us_q <= us_q + 48'(pu_s2);
		end else if (v2_s2)
			gs_q <= gs_q + 48'(pg_s2);
	end

	// projections rounded, SiLU by table and interpolation, gating, down sum rounded
	logic signed [35:0] gp_q, up_q;
	logic signed [35:0] silu_q;
	logic signed [47:0] ws_q;
	logic [7:0] ti, ti1;
	logic [7:0] tf;
	logic [15:0] toff;
	logic signed [17:0] ta, tb;
	logic signed [27:0] tdf;
	logic signed [63:0] gprod;
	logic signed [47:0] wprod;
	logic signed [32:0] acc_sum;

	assign toff = 16'(gp_q + 36'sd32768);
	assign ti = toff[15:8];
	assign tf = toff[7:0];
	assign ti1 = ti + 8'd1;
	assign ta = gfea_pkg::SILU_TAB[ti];
	assign tb = (ti == 8'hFF) ? 18'sd32768 : gfea_pkg::SILU_TAB[ti1];
	assign tdf = 28'(tb - ta) * $signed({1'b0, tf});
	// rounded projections stay within 25 bits signed
	assign gprod = 64'(25'(silu_q)) * 64'(25'(up_q));

	always_ff @(posedge clk) begin
		if (cmd.p1_round) begin
			gp_q <= 36'(gfea_pkg::rnd_shift(64'(gs_q), 12));
			up_q <= 36'(gfea_pkg::rnd_shift(64'(us_q), 12));
		end
		if (cmd.p1_silu) begin
			if (gp_q < -36'sd32768)
				silu_q <= '0;
			else if (gp_q >= 36'sd32768)
				silu_q <= gp_q;
			else
				silu_q <= 36'(ta) + 36'((tdf + 28'sd128) >>> 8);
		end
		if (cmd.p1_gate) begin
			if (gfea_pkg::rnd_shift(gprod, 12) > 64'sd32767)
				gv_mem[cmd.j[IW-1:0]] <= 16'sh7FFF;
			else if (gfea_pkg::rnd_shift(gprod, 12) < -64'sd32768)
				gv_mem[cmd.j[IW-1:0]] <= -16'sh8000;
			else
				gv_mem[cmd.j[IW-1:0]] <= 16'(gfea_pkg::rnd_shift(gprod, 12));
		end
		if (cmd.p2_scale)
			ws_q <= 48'(gfea_pkg::rnd_shift(64'(gs_q), 12));
	end

	// the rounded down sum stays within 26 bits signed
	assign wprod = 48'(gfea_pkg::rnd_shift(64'(26'(ws_q)) * 64'($signed({1'b0, rw_q})), 15));
	assign acc_sum = 33'(acc_q[cmd.j[HW-1:0]]) + 33'(wprod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HID_MAX; i++)
				acc_q[i] <= '0;
		end else if (cmd.clr_acc) begin
			for (int i = 0; i < HID_MAX; i++)
				acc_q[i] <= '0;
		end else if (cmd.p2_acc) begin
			if (wprod > 48'sd2147483647 || acc_sum > 33'sd2147483647)
				acc_q[cmd.j[HW-1:0]] <= 32'sh7FFFFFFF;
			else if (wprod < -48'sd2147483648 || acc_sum < -33'sd2147483648)
				acc_q[cmd.j[HW-1:0]] <= 32'sh80000000;
			else
				acc_q[cmd.j[HW-1:0]] <= 32'(acc_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.element_index <= cmd.j[4:0];
			result.element_value <= acc_q[cmd.j[HW-1:0]];
			result.last          <= cmd.last;
		end
	end

`ifndef SYNTHESIS
	a_mac_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(v1_s2 && v2_s2))
		else $error("both projection passes active");
	a_emit_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> $past(cmd.p2_acc))
		else $error("emit without accumulate");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_acc |=> acc_q[0] == 32'sd0)
		else $error("accumulator not cleared");
`endif

endmodule

// File: rtl/gated_ffn_expert_accumulator.sv
// Top level of the gated feed-forward expert accumulator.
// Joins gfea_ctrl and gfea_datapath, holds the configuration registers; uses gfea_pkg.
//
// channel   handshake            payload
// in        start / busy         in_item   (gfea_pkg::in_item_t)
// out       out_valid strobe     out_item  (gfea_pkg::out_item_t)
// cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A compute is paced by the single shared gate/up MAC pair walking the weight memories
// one word a cycle. Reset clears control and the output accumulator; weight memories hold
// garbage until loaded. Results leave one per strobe cycle and cannot be stalled; register
// writes wait for idle.
module gated_ffn_expert_accumulator #(
	parameter int HID_MAX     = gfea_pkg::HID_MAX_DEF,
	parameter int INTER_SIZE  = gfea_pkg::INTER_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gfea_pkg::in_item_t  in_item,
	output logic                out_valid,
	output gfea_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [6:0]          cfg_data
);

	logic [5:0] hid_q;
	logic [6:0] int_q;
	logic [7:0] h_cnt;
	logic [8:0] n_cnt;
	logic acc;
	gfea_pkg::dp_cmd_t cmd;

	assign cfg_ready = !busy;
	assign acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hid_q <= 6'd32;
			int_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == gfea_pkg::CFG_HIDDEN)
				hid_q <= cfg_data[5:0];
			else
				int_q <= cfg_data;
		end
	end

	always_comb begin
		if (hid_q == '0)
			h_cnt = 8'd1;
		else if (32'(hid_q) > HID_MAX)
			h_cnt = 8'(HID_MAX);
		else
			h_cnt = {2'b0, hid_q};
		if (int_q == '0)
			n_cnt = 9'd1;
		else if (32'(int_q) > INTER_SIZE)
			n_cnt = 9'(INTER_SIZE);
		else
			n_cnt = {2'b0, int_q};
	end

	gfea_ctrl #(.HID_MAX(HID_MAX), .INTER_SIZE(INTER_SIZE)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.go_compute(acc && in_item.action == gfea_pkg::ACT_COMPUTE),
		.go_clear(acc && in_item.action == gfea_pkg::ACT_CLEAR),
		.h_cnt(h_cnt), .n_cnt(n_cnt), .busy(busy), .cmd(cmd)
	);

	gfea_datapath #(.HID_MAX(HID_MAX), .INTER_SIZE(INTER_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .load_en(acc), .item(in_item),
		.latch_rw(acc && in_item.action == gfea_pkg::ACT_COMPUTE),
		.cmd(cmd), .result(out_item), .result_valid(out_valid)
	);

endmodule

// File: bench/testbench.sv
// Self-checking bench for gated_ffn_expert_accumulator: loads, computes, clears, register writes.
// Predicts every emitted accumulator element in-bench; depends on gfea_pkg and the RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gfea_pkg::*;

	localparam int HID = 32;
	localparam int INTR = 64;
	// computes only ever reach this corner of the stores
	localparam int H_T = 4;
	localparam int I_T = 6;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	in_item_t  in_item = '0;
	logic      out_valid;
	out_item_t out_item;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = CFG_HIDDEN;
	logic [6:0] cfg_data = '0;

	gated_ffn_expert_accumulator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// mirror of the block's state
	shortint  gate_w [HID][INTR];
	shortint  up_w [HID][INTR];
	shortint  down_w [INTR][HID];
	shortint  token_x [HID];
	shortint  gated_v [INTR];
	int       accum [HID];
	int       silu_lut [256];
	int       hid_reg = 32;
	int       int_reg = 64;

	in_item_t  pending_items [$];
	out_item_t expected_elems [$];
	int        idle_pct = 0;
	bit        failed = 1'b0;

	function automatic void enqueue(in_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void fill_silu_lut();
		longint unsigned e, den, num, ax;
		int n, mag;
		for (int i = 0; i < 256; i++) begin
			n = i - 128;
			mag = n < 0 ? -n : n;
			ax = longint'(mag) * 256;
			e = 64'd1 << 32;
			for (int k = 0; k < mag; k++)
				e = (k == 0) ? 64'd4034748381 : ((e * 64'd4034748381 + (64'd1 << 31)) >> 32);
			den = (64'd1 << 32) + e;
			num = (n >= 0) ? (ax << 32) : ax * e;
			silu_lut[i] = (n >= 0) ? int'((num + den / 2) / den) : -int'((num + den / 2) / den);
		end
	endfunction

	function automatic longint silu(longint p);
		int o, idx, f;
		longint a, b;
		if (p < -32768)
			return 0;
		if (p >= 32768)
			return p;
		o = int'(p + 32768);
		idx = o >> 8;
		f = o & 255;
		a = silu_lut[idx];
		b = (idx == 255) ? 32768 : silu_lut[idx + 1];
		return a + round_shift((b - a) * f, 8);
	endfunction

	function automatic int used_count(int v, int max);
		return v == 0 ? 1 : (v > max ? max : v);
	endfunction

	// apply one accepted transaction and queue the row it emits
	function automatic void apply_item(in_item_t it);
		int h, n;
		longint gs, us, g, u, ds, s, w;
		out_item_t r;
		case (it.action)
			ACT_LOAD_W: begin
				if ((it.matrix_sel == SEL_GATE) && it.row_index < HID)
					gate_w[it.row_index][it.col_index] = it.value;
				else if ((it.matrix_sel == SEL_UP) && it.row_index < HID)
					up_w[it.row_index][it.col_index] = it.value;
				else if ((it.matrix_sel == SEL_DOWN) && it.col_index < HID)
					down_w[it.row_index][it.col_index] = it.value;
			end
			ACT_LOAD_X: begin
				if (it.col_index < HID)
					token_x[it.col_index] = it.value;
			end
			ACT_CLEAR: begin
				for (int j = 0; j < HID; j++)
					accum[j] = 0;
			end
			default: begin
				h = used_count(hid_reg, HID);
				n = used_count(int_reg, INTR);
				for (int j = 0; j < n; j++) begin
					gs = 0;
					us = 0;
					for (int k = 0; k < h; k++) begin
						gs += longint'(token_x[k]) * gate_w[k][j];
						us += longint'(token_x[k]) * up_w[k][j];
					end
					g = silu(round_shift(gs, 12));
					u = round_shift(us, 12);
					gated_v[j] = shortint'(clip(round_shift(g * u, 12), -32768, 32767));
				end
				for (int j = 0; j < h; j++) begin
					ds = 0;
					for (int k = 0; k < n; k++)
						ds += longint'(gated_v[k]) * down_w[k][j];
					s = round_shift(ds, 12);
					w = round_shift(s * longint'(it.route_gain), 15);
					accum[j] = int'(clip(longint'(accum[j]) + w, -64'sd2147483648, 64'sd2147483647));
					r.element_index = 5'(j);
					r.element_value = accum[j];
					r.last = (j == h - 1);
					expected_elems.insert(expected_elems.size(), r);
				end
			end
		endcase
	endfunction

	// drive the start/busy channel from the pending queue
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				apply_item(in_item);
			if (start && busy) begin
				// hold the current transaction
			end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (expected_elems.size() == 0) begin
				$error("unexpected element index %0d value %0d", out_item.element_index,
					out_item.element_value);
				failed = 1'b1;
			end else begin
				out_item_t e;
				e = expected_elems.pop_front();
				if (out_item.element_index !== e.element_index) begin
					$error("element_index expected %0d actual %0d", e.element_index,
						out_item.element_index);
					failed = 1'b1;
				end
				if (out_item.element_value !== e.element_value) begin
					$error("element_value expected %0d actual %0d", e.element_value,
						out_item.element_value);
					failed = 1'b1;
				end
				if (out_item.last !== e.last) begin
					$error("last expected %0d actual %0d", e.last, out_item.last);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic in_item_t make_item(logic [1:0] act, logic [1:0] sel, int row, int col,
		int val, int rw);
		in_item_t it;
		it.action = act;
		it.matrix_sel = sel;
		it.row_index = 6'(row);
		it.col_index = 6'(col);
		it.value = 16'(val);
		it.route_gain = 16'(rw);
		return it;
	endfunction

	// mostly within +-0.5, now and then full range
	function automatic int rand_q12();
		if ($urandom_range(7) == 0)
			return int'($urandom_range(65535)) - 32768;
		return int'($urandom_range(4095)) - 2048;
	endfunction

	function automatic in_item_t random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return (pick % 3 == 2) ?
				make_item(ACT_LOAD_W, SEL_DOWN, $urandom_range(63), $urandom_range(31), rand_q12(), 0) :
				make_item(ACT_LOAD_W, 2'(pick % 3), $urandom_range(31), $urandom_range(63),
					rand_q12(), $urandom_range(65535));
		if (pick < 62)
			return make_item(ACT_LOAD_X, 2'($urandom_range(3)), $urandom_range(63),
				$urandom_range(31), rand_q12(), $urandom_range(65535));
		if (pick < 78)
			return make_item(ACT_COMPUTE, 2'($urandom_range(3)), $urandom_range(63),
				$urandom_range(63), $urandom_range(65535), $urandom_range(65535));
		if (pick < 83)
			return make_item(ACT_CLEAR, 2'($urandom_range(3)), $urandom_range(63),
				$urandom_range(63), $urandom_range(65535), $urandom_range(65535));
		// noise: loads of either kind with any select and indices, some out of range
		return make_item(2'($urandom_range(1)), 2'($urandom_range(3)), $urandom_range(63),
			$urandom_range(63), $urandom_range(65535), $urandom_range(65535));
	endfunction

	task automatic settle();
		while (pending_items.size() > 0 || start)
			@(posedge clk);
		while (expected_elems.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 7'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_HIDDEN)
			hid_reg = val & 63;
		else
			int_reg = val & 127;
	endtask

	initial begin
		int hid_set [4] = '{0, 4, 3, 2};
		int int_set [4] = '{0, 6, 5, 3};
		int pct_set [4] = '{0, 66, 0, 13};
		fill_silu_lut();
		for (int j = 0; j < HID; j++)
			accum[j] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// keep computes inside the corner that gets written below
		write_reg(CFG_HIDDEN, H_T);
		write_reg(CFG_INTER, I_T);

		// write every entry a compute can read
		for (int r = 0; r < H_T; r++)
			for (int c = 0; c < I_T; c++) begin
				enqueue(make_item(ACT_LOAD_W, SEL_GATE, r, c, rand_q12(), 0));
				enqueue(make_item(ACT_LOAD_W, SEL_UP, r, c, rand_q12(), 0));
				enqueue(make_item(ACT_LOAD_W, SEL_DOWN, c, r, rand_q12(), 0));
			end
		for (int c = 0; c < H_T; c++)
			enqueue(make_item(ACT_LOAD_X, SEL_GATE, 0, c, rand_q12(), 0));

		// extremes, ignored loads, every action
		enqueue(make_item(ACT_LOAD_W, SEL_GATE, 0, 0, 32767, 0));
		enqueue(make_item(ACT_LOAD_W, SEL_UP, 31, 63, -32768, 0));
		enqueue(make_item(ACT_LOAD_W, SEL_DOWN, 63, 31, 32767, 65535));
		enqueue(make_item(ACT_LOAD_X, SEL_DOWN, 63, 0, 32767, 0));
		enqueue(make_item(ACT_LOAD_X, SEL_GATE, 0, 31, -32768, 0));
		enqueue(make_item(ACT_COMPUTE, SEL_GATE, 0, 0, 0, 32768));
		enqueue(make_item(ACT_COMPUTE, SEL_GATE, 0, 0, 0, 65535));
		enqueue(make_item(ACT_COMPUTE, SEL_GATE, 0, 0, 0, 0));
		enqueue(make_item(ACT_LOAD_W, 2'd3, 0, 0, 12345, 0));
		enqueue(make_item(ACT_LOAD_W, SEL_GATE, 32, 0, -1, 0));
		enqueue(make_item(ACT_LOAD_W, SEL_UP, 63, 5, -1, 0));
		enqueue(make_item(ACT_LOAD_W, SEL_DOWN, 0, 32, -1, 0));
		enqueue(make_item(ACT_LOAD_W, SEL_DOWN, 0, 63, -1, 0));
		enqueue(make_item(ACT_LOAD_X, SEL_GATE, 0, 32, -1, 0));
		enqueue(make_item(ACT_LOAD_X, SEL_GATE, 0, 63, -1, 0));
		enqueue(make_item(ACT_COMPUTE, SEL_UP, 63, 63, -1, 1));
		enqueue(make_item(ACT_CLEAR, SEL_GATE, 0, 0, 0, 0));
		enqueue(make_item(ACT_CLEAR, 2'd3, 63, 63, -1, 65535));
		enqueue(make_item(ACT_COMPUTE, SEL_GATE, 0, 0, 0, 32768));
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_HIDDEN, hid_set[ph]);
			write_reg(CFG_INTER, int_set[ph]);
			idle_pct = pct_set[ph];
			for (int i = 0; i < 20; i++)
				enqueue(random_item());
			enqueue(make_item(ACT_COMPUTE, SEL_GATE, 0, 0, 0, $urandom_range(65535)));
			// pause the sender until the row is fully out
			settle();
		end

		if (!failed)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/gfea_pkg.sv
rtl/gfea_ctrl.sv
rtl/gfea_datapath.sv
rtl/gated_ffn_expert_accumulator.sv
bench/testbench.sv
